FILE: rtl/dqnf_pkg.sv
// ----------------------------------------------------------------------------
// dqnf_pkg: shared types, constants and rule tables of the DNS name filter
// Holds the phase and status codes, the transaction passed from the name
// parser to the rule bank, and elaboration-time functions that turn each
// rule text into the position masks of its automaton.
// ----------------------------------------------------------------------------
package dqnf_pkg;

	// Rule table geometry
	localparam int TABLE_RULES = 5;
	localparam int TABLE_CHARS = 17;
	localparam int PAT_LIMIT   = 64;
	localparam int QUEUE_DEPTH = 4;

	// Pattern metacharacters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	// Built-in rule texts, right-justified and zero padded on the left
	typedef logic [8*TABLE_CHARS-1:0] rule_text_t;

	localparam rule_text_t RULE_TEXT [TABLE_RULES] = '{
		rule_text_t'({"^.*.g", "oogle.com$"}),
		rule_text_t'({"^.*.f", "acebook.com$"}),
		rule_text_t'({"^.*.y", "outube.com$"}),
		rule_text_t'({"^.*.a", "mazon.com$"}),
		rule_text_t'({"^.*.t", "witter.com$"})
	};

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_LABEL  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EARLY_END = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// One transaction from the parser to the rule bank
	typedef struct packed {
		logic       adv;       // advance the automata by ch
		logic [7:0] ch;
		logic       emit;      // produce a result
		status_t    status;
		logic [7:0] name_len;
		logic       restart;   // return the automata to their start state
	} dqnf_event_t;

	// Number of characters in a rule text
	function automatic int text_len(int r);
		int n;
		int k;
		n = 0;
		for (k = 0; k < TABLE_CHARS; k++) begin
			if (RULE_TEXT[r][8*k +: 8] != CH_NUL)
				n++;
		end
		return n;
	endfunction

	// Character i of a rule text, counted from its first character
	function automatic logic [7:0] text_char(int r, int i);
		int n;
		n = text_len(r);
		if (i >= n)
			return CH_NUL;
		return RULE_TEXT[r][8*(n-1-i) +: 8];
	endfunction

	function automatic int body_start(int r);
		return (text_char(r, 0) == CH_CARET) ? 1 : 0;
	endfunction

	function automatic int body_len(int r, int maxp);
		int bs;
		int n;
		bs = body_start(r);
		n  = text_len(r) - bs;
		if (maxp - bs < n)
			n = maxp - bs;
		if (n > 63)
			n = 63;
		return n;
	endfunction

	function automatic logic [7:0] pat_at(int r, int p, int maxp);
		if (p >= body_len(r, maxp))
			return CH_NUL;
		return text_char(r, body_start(r) + p);
	endfunction

	function automatic bit is_end_anchor(int r, int p, int maxp);
		return (pat_at(r, p, maxp) == CH_DOLLAR) && (pat_at(r, p + 1, maxp) == CH_NUL);
	endfunction

	// Position that can consume a character
	function automatic bit is_live(int r, int p, int maxp);
		return (p < body_len(r, maxp)) && !is_end_anchor(r, p, maxp);
	endfunction

	// Position reached after consuming a character at p
	function automatic int fire_target(int r, int p, int maxp);
		logic [7:0] y;
		y = pat_at(r, p + 1, maxp);
		if (y == CH_STAR)
			return p;
		if (y == CH_QMARK)
			return p + 2;
		return p + 1;
	endfunction

	function automatic bit has_eps(int r, int p, int maxp);
		logic [7:0] y;
		y = pat_at(r, p + 1, maxp);
		return (p < body_len(r, maxp)) && (y == CH_STAR || y == CH_QMARK);
	endfunction

	// Follow optional elements from p; report whether q is reached
	function automatic bit reaches(int r, int p, int q, int maxp);
		int bl;
		int cur;
		int k;
		bit done;
		bit found;
		bl    = body_len(r, maxp);
		cur   = p;
		done  = (p >= bl);
		found = 1'b0;
		for (k = 0; k < PAT_LIMIT; k++) begin
			if (!done) begin
				if (cur == q)
					found = 1'b1;
				if (has_eps(r, cur, maxp)) begin
					cur = cur + 2;
					if (cur >= bl)
						done = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		end
		return found;
	endfunction

	// Follow optional elements from p; report whether the pattern end is reached
	function automatic bit reaches_end(int r, int p, int maxp);
		int bl;
		int cur;
		int k;
		bit done;
		bit hit;
		bl   = body_len(r, maxp);
		cur  = p;
		done = (p >= bl);
		hit  = 1'b0;
		for (k = 0; k < PAT_LIMIT; k++) begin
			if (!done) begin
				if (has_eps(r, cur, maxp)) begin
					cur = cur + 2;
					if (cur >= bl) begin
						hit  = 1'b1;
						done = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	// Positions whose firing lands on q
	function automatic logic [PAT_LIMIT-1:0] src_mask(int r, int q, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int p;
		m = '0;
		for (p = 0; p < PAT_LIMIT; p++) begin
			if (is_live(r, p, maxp) && fire_target(r, p, maxp) == q)
				m[p] = 1'b1;
		end
		return m;
	endfunction

	// Positions whose firing runs off the pattern end
	function automatic logic [PAT_LIMIT-1:0] hit_src_mask(int r, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int p;
		m = '0;
		for (p = 0; p < PAT_LIMIT; p++) begin
			if (is_live(r, p, maxp) && fire_target(r, p, maxp) >= body_len(r, maxp))
				m[p] = 1'b1;
		end
		return m;
	endfunction

	// Positions whose closure contains q
	function automatic logic [PAT_LIMIT-1:0] clo_col(int r, int q, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int p;
		m = '0;
		for (p = 0; p < PAT_LIMIT; p++) begin
			if (reaches(r, p, q, maxp))
				m[p] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [PAT_LIMIT-1:0] clo_hit_mask(int r, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int p;
		m = '0;
		for (p = 0; p < PAT_LIMIT; p++) begin
			if (reaches_end(r, p, maxp))
				m[p] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [PAT_LIMIT-1:0] end_mask(int r, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int p;
		m = '0;
		for (p = 0; p < PAT_LIMIT; p++) begin
			if (p < body_len(r, maxp) && is_end_anchor(r, p, maxp))
				m[p] = 1'b1;
		end
		return m;
	endfunction

	// Start state: position 0 closed over optional elements
	function automatic logic [PAT_LIMIT-1:0] reset_mask(int r, int maxp);
		logic [PAT_LIMIT-1:0] m;
		int q;
		m = '0;
		for (q = 0; q < PAT_LIMIT; q++) begin
			if (q < body_len(r, maxp) && reaches(r, 0, q, maxp))
				m[q] = 1'b1;
		end
		return m;
	endfunction

	function automatic bit reset_hit(int r, int maxp);
		return (body_len(r, maxp) == 0) || reaches_end(r, 0, maxp);
	endfunction

endpackage

FILE: rtl/dqnf_fifo.sv
// ----------------------------------------------------------------------------
// dqnf_fifo: transaction queue between name parser and rule bank
// A small flip-flop queue that lets the parser keep taking bytes while the
// result side is stalled, and the rule bank drain while input is idle.
// ----------------------------------------------------------------------------
module dqnf_fifo import dqnf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  dqnf_event_t push_ev,
	output logic        full,
	input  logic        pop,
	output dqnf_event_t pop_ev,
	output logic        empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dqnf_event_t    entry_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_ev = entry_q[rd_ptr_q];

	// Store incoming transactions
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_ev;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

FILE: rtl/dqnf_front.sv
// ----------------------------------------------------------------------------
// dqnf_front: header skip and query name decoder
// Walks the message byte by byte, tracks the label structure and name
// length, and turns each byte into at most one transaction for the rule bank.
// ----------------------------------------------------------------------------
module dqnf_front import dqnf_pkg::*; #(
	parameter int MAX_NAME_CHARS = 255,
	parameter int HEADER_BYTES   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  message_byte,
	input  logic        end_of_message,
	input  logic        q_full,
	output logic        push,
	output dqnf_event_t push_ev
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_NAME_CHARS);
	localparam logic [3:0] HDR_LEN = 4'(HEADER_BYTES);

	phase_t      phase_q, phase_d, ph_eff;
	logic [3:0]  header_count_q, header_count_d;
	logic [7:0]  label_remaining_q, label_remaining_d;
	logic [7:0]  decoded_length_q, decoded_length_d;
	logic        sep_pending_q, sep_pending_d;
	logic        text_closed_q, text_closed_d;
	logic        accept;
	dqnf_event_t ev;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (ev.adv || ev.emit || ev.restart);
	assign push_ev  = ev;

	// Decode one byte: next state and transaction
	always_comb begin
		phase_d           = phase_q;
		header_count_d    = header_count_q;
		label_remaining_d = label_remaining_q;
		decoded_length_d  = decoded_length_q;
		sep_pending_d     = sep_pending_q;
		text_closed_d     = text_closed_q;
		ph_eff            = phase_q;
		ev                = '0;
		ev.status         = ST_OK;

		// skip the header, then treat this byte as the first length byte
		if (phase_q == PH_HEADER) begin
			if (header_count_q < HDR_LEN)
				header_count_d = header_count_q + 4'd1;
			else
				ph_eff = PH_LENGTH;
		end
		phase_d = ph_eff;

		case (ph_eff)
			PH_LENGTH: begin
				if (message_byte == 8'd0) begin
					ev.emit     = 1'b1;
					ev.status   = ST_OK;
					ev.name_len = decoded_length_q;
					phase_d     = PH_DONE;
				end else if (sep_pending_q && decoded_length_q >= MAX_LEN) begin
					ev.emit     = 1'b1;
					ev.status   = ST_TOO_LONG;
					ev.name_len = MAX_LEN;
					phase_d     = PH_DONE;
				end else begin
					// dot between labels
					if (sep_pending_q) begin
						decoded_length_d = decoded_length_q + 8'd1;
						ev.adv           = !text_closed_q;
						ev.ch            = CH_DOT;
					end
					label_remaining_d = message_byte;
					sep_pending_d     = 1'b1;
					phase_d           = PH_LABEL;
				end
			end
			PH_LABEL: begin
				if (decoded_length_q >= MAX_LEN) begin
					ev.emit     = 1'b1;
					ev.status   = ST_TOO_LONG;
					ev.name_len = MAX_LEN;
					phase_d     = PH_DONE;
				end else begin
					decoded_length_d = decoded_length_q + 8'd1;
					// a zero character ends the text seen by the automata
					if (!text_closed_q) begin
						if (message_byte == 8'd0) begin
							text_closed_d = 1'b1;
						end else begin
							ev.adv = 1'b1;
							ev.ch  = message_byte;
						end
					end
					label_remaining_d = label_remaining_q - 8'd1;
					if (label_remaining_q == 8'd1)
						phase_d = PH_LENGTH;
				end
			end
			default: begin
			end
		endcase

		// last byte: report an unfinished name, then restart
		if (end_of_message) begin
			if (!ev.emit && phase_d != PH_DONE) begin
				ev.emit     = 1'b1;
				ev.status   = ST_EARLY_END;
				ev.name_len = decoded_length_d;
			end
			ev.restart        = 1'b1;
			phase_d           = PH_HEADER;
			header_count_d    = '0;
			label_remaining_d = '0;
			decoded_length_d  = '0;
			sep_pending_d     = 1'b0;
			text_closed_d     = 1'b0;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HEADER;
			header_count_q    <= '0;
			label_remaining_q <= '0;
			decoded_length_q  <= '0;
			sep_pending_q     <= 1'b0;
			text_closed_q     <= 1'b0;
		end else if (accept) begin
			phase_q           <= phase_d;
			header_count_q    <= header_count_d;
			label_remaining_q <= label_remaining_d;
			decoded_length_q  <= decoded_length_d;
			sep_pending_q     <= sep_pending_d;
			text_closed_q     <= text_closed_d;
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_message) |=> (phase_q == PH_HEADER && decoded_length_q == 8'd0))
		else $error("message end did not restart the parser");

	a_label_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LABEL) |-> (sep_pending_q && label_remaining_q != 8'd0))
		else $error("label phase without a pending length");

	a_too_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_ev.emit && push_ev.status == ST_TOO_LONG) |-> (push_ev.name_len == MAX_LEN))
		else $error("overlong name reported with wrong length");

endmodule

FILE: rtl/dqnf_match.sv
// ----------------------------------------------------------------------------
// dqnf_match: rule automata bank and result register
// One position-mask automaton per rule steps on each decoded character;
// finishing transactions load the result register.
// ----------------------------------------------------------------------------
module dqnf_match import dqnf_pkg::*; #(
	parameter int RULE_COUNT        = 5,
	parameter int MAX_PATTERN_CHARS = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	input  dqnf_event_t ev,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        blocked,
	output logic [1:0]  status,
	output logic [7:0]  name_length
);

	localparam int W          = MAX_PATTERN_CHARS;
	localparam int RULES_USED = (RULE_COUNT < TABLE_RULES) ? RULE_COUNT : TABLE_RULES;

	logic [RULES_USED-1:0] rule_match;
	logic                  any_match;
	logic                  out_valid_q;
	logic                  blocked_q;
	status_t               status_q;
	logic [7:0]            name_length_q;

	// Take a transaction unless it emits into a full result register that is not being read
	assign pop = ev_valid && (!ev.emit || !out_valid_q || out_ready);

	for (genvar r = 0; r < RULES_USED; r++) begin : g_rule
		localparam int                   BL      = body_len(r, W);
		localparam bit                   ANCHOR  = (body_start(r) == 1);
		localparam bit                   SEED    = !ANCHOR && (BL > 0);
		localparam bit                   SEED_HIT = !ANCHOR && (BL == 0);
		localparam logic [PAT_LIMIT-1:0] HIT_SRC = hit_src_mask(r, W);
		localparam logic [PAT_LIMIT-1:0] CLO_HIT = clo_hit_mask(r, W);
		localparam logic [PAT_LIMIT-1:0] END_POS = end_mask(r, W);
		localparam logic [PAT_LIMIT-1:0] START   = reset_mask(r, W);
		localparam bit                   START_HIT = reset_hit(r, W);

		logic [W-1:0] state_q;
		logic [W-1:0] fire;
		logic [W-1:0] pre;
		logic [W-1:0] closed;
		logic         hit_q;
		logic         hit_now;

		// Character test at each position
		for (genvar p = 0; p < W; p++) begin : g_pos
			localparam logic [7:0] X    = pat_at(r, p, W);
			localparam bit         LIVE = is_live(r, p, W);
			assign fire[p] = LIVE && state_q[p] && (X == CH_DOT || ev.ch == X);
		end

		// Route firings to their targets, then close over optional elements
		for (genvar q = 0; q < W; q++) begin : g_tgt
			localparam logic [PAT_LIMIT-1:0] SRC  = src_mask(r, q, W);
			localparam logic [PAT_LIMIT-1:0] COL  = clo_col(r, q, W);
			localparam bit                   SEED_HERE = SEED && (q == 0);
			assign pre[q]    = (|(fire & SRC[W-1:0])) || SEED_HERE;
			assign closed[q] = |(pre & COL[W-1:0]);
		end

		assign hit_now = (|(fire & HIT_SRC[W-1:0])) || SEED_HIT || (|(pre & CLO_HIT[W-1:0]));
		assign rule_match[r] = hit_q || (|(state_q & END_POS[W-1:0]));

		// Automaton state
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				state_q <= START[W-1:0];
				hit_q   <= START_HIT;
			end else if (pop) begin
				if (ev.restart) begin
					state_q <= START[W-1:0];
					hit_q   <= START_HIT;
				end else if (ev.adv) begin
					state_q <= closed;
					hit_q   <= hit_q || hit_now;
				end
			end
		end
	end

	assign any_match = |rule_match;

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && ev.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && ev.emit) begin
			blocked_q     <= (ev.status == ST_OK) && any_match;
			status_q      <= ev.status;
			name_length_q <= ev.name_len;
		end
	end

	assign out_valid   = out_valid_q;
	assign blocked     = blocked_q;
	assign status      = status_q;
	assign name_length = name_length_q;

	a_no_emit_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && ev.emit && out_valid_q && !out_ready))
		else $error("result register overwritten while stalled");

endmodule

FILE: rtl/dns_query_name_filter.sv
// ----------------------------------------------------------------------------
// dns_query_name_filter: DNS query name rule filter
// Skips the message header, decodes the query name and reports whether it
// matches any built-in rule, with a status and the decoded name length.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, message_byte,         | to block
//          | end_of_message                            |
//  out     | out_valid, out_ready, blocked, status,    | from block
//          | name_length                               |
//
//  One byte per cycle is taken while the queue is not full; the parser decides
//  each byte in the cycle it is accepted, and the rule automata step once per
//  queued transaction. The result for the finishing byte goes through the queue
//  and then the result register. A stalled output fills the four-entry queue,
//  then in_ready drops. Reset is asynchronous and needs no clearing pass: the
//  block takes bytes as soon as reset is released.
//
module dns_query_name_filter import dqnf_pkg::*; #(
	parameter int RULE_COUNT        = 5,
	parameter int MAX_NAME_CHARS    = 255,
	parameter int HEADER_BYTES      = 12,
	parameter int MAX_PATTERN_CHARS = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] message_byte,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       blocked,
	output logic [1:0] status,
	output logic [7:0] name_length
);

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	dqnf_event_t push_ev;
	dqnf_event_t pop_ev;

	// Parser front end
	dqnf_front #(
		.MAX_NAME_CHARS (MAX_NAME_CHARS),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.message_byte   (message_byte),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.push           (q_push),
		.push_ev        (push_ev)
	);

	// Decoupling queue
	dqnf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_ev (push_ev),
		.full    (q_full),
		.pop     (q_pop),
		.pop_ev  (pop_ev),
		.empty   (q_empty)
	);

	// Rule bank and result register
	dqnf_match #(
		.RULE_COUNT        (RULE_COUNT),
		.MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (!q_empty),
		.ev          (pop_ev),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.blocked     (blocked),
		.status      (status),
		.name_length (name_length)
	);

endmodule
